[rtl/u8u16_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants of the UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  localparam logic [1:0] KIND_UNIT  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam int SLOTS       = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_text;
  } in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [15:0] code_unit;
    logic        last_result;
  } out_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [15:0] code_unit;
  } slot_t;

  typedef struct packed {
    logic [1:0]           num;
    slot_t [SLOTS-1:0]    slot;
  } job_t;

endpackage

[rtl/u8u16_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16_front
// Decodes one byte per transfer and builds the list of results it causes.
// ----------------------------------------------------------------------------
module u8u16_front import u8u16_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  cfg_wr_en,
  input  logic  cfg_wr_data,
  input  logic  accept,
  input  in_t   in_data,
  output logic  push,
  output job_t  job
);

  logic        validate_only_r;
  logic [1:0]  pend_r, pend_nxt;
  logic [1:0]  slen_r, slen_nxt;
  logic [20:0] pval_r, pval_nxt;
  logic        disc_r, disc_nxt;

  logic [1:0]  cnt;
  logic [20:0] cp;
  logic        emit;
  logic        err;
  logic        bad;
  logic [20:0] acc;
  logic [20:0] min_cp;
  logic [20:0] adj;
  logic [7:0]  b;

  always_comb begin
    b        = in_data.data_byte;
    pend_nxt = pend_r;
    slen_nxt = slen_r;
    pval_nxt = pval_r;
    disc_nxt = disc_r;
    cnt      = 2'd0;
    job      = '0;
    emit     = 1'b0;
    err      = 1'b0;
    bad      = 1'b0;
    cp       = '0;
    acc      = {pval_r[14:0], b[5:0]};
    adj      = '0;
    unique case (slen_r)
      2'd1:    min_cp = 21'h80;
      2'd2:    min_cp = 21'h800;
      2'd3:    min_cp = 21'h10000;
      default: min_cp = 21'h0;
    endcase

    if (in_data.byte_present && !disc_r) begin
      if (pend_r == 2'd0) begin
        if (b[7] == 1'b0) begin
          emit = 1'b1;
          cp   = {13'd0, b};
        end else if (b[7:5] == 3'b110) begin
          pend_nxt = 2'd1;
          slen_nxt = 2'd1;
          pval_nxt = {16'd0, b[4:0]};
        end else if (b[7:4] == 4'b1110) begin
          pend_nxt = 2'd2;
          slen_nxt = 2'd2;
          pval_nxt = {17'd0, b[3:0]};
        end else if (b[7:3] == 5'b11110) begin
          pend_nxt = 2'd3;
          slen_nxt = 2'd3;
          pval_nxt = {18'd0, b[2:0]};
        end else begin
          err = 1'b1;
        end
      end else if (b[7:6] != 2'b10) begin
        err = 1'b1;
      end else begin
        pval_nxt = acc;
        pend_nxt = pend_r - 2'd1;
        if (pend_r == 2'd1) begin
          bad = (acc < min_cp) || (acc > 21'h10FFFF) ||
                ((acc >= 21'hD800) && (acc <= 21'hDFFF));
          if (bad) begin
            err = 1'b1;
          end else begin
            emit     = 1'b1;
            cp       = acc;
            slen_nxt = 2'd0;
            pval_nxt = '0;
          end
        end
      end
    end

    adj = cp - 21'h10000;
    if (emit && !validate_only_r) begin
      if (cp <= 21'hFFFF) begin
        job.slot[cnt] = '{result_kind: KIND_UNIT, code_unit: cp[15:0]};
        cnt = cnt + 2'd1;
      end else begin
        job.slot[cnt] = '{result_kind: KIND_UNIT,
                          code_unit: 16'hD800 + {6'd0, adj[19:10]}};
        cnt = cnt + 2'd1;
        job.slot[cnt] = '{result_kind: KIND_UNIT,
                          code_unit: 16'hDC00 + {6'd0, adj[9:0]}};
        cnt = cnt + 2'd1;
      end
    end
    if (err) begin
      job.slot[cnt] = '{result_kind: KIND_ERROR, code_unit: 16'd0};
      cnt      = cnt + 2'd1;
      disc_nxt = 1'b1;
      pend_nxt = 2'd0;
      slen_nxt = 2'd0;
      pval_nxt = '0;
    end

    if (in_data.end_of_text) begin
      if (!disc_nxt) begin
        job.slot[cnt] = '{result_kind: (pend_nxt != 2'd0) ? KIND_ERROR : KIND_DONE,
                          code_unit: 16'd0};
        cnt = cnt + 2'd1;
      end
      pend_nxt = 2'd0;
      slen_nxt = 2'd0;
      pval_nxt = '0;
      disc_nxt = 1'b0;
    end

    job.num = cnt;
    push    = accept && (cnt != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      validate_only_r <= 1'b0;
      pend_r          <= '0;
      slen_r          <= '0;
      pval_r          <= '0;
      disc_r          <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        validate_only_r <= cfg_wr_data;
      end
      if (accept) begin
        pend_r <= pend_nxt;
        slen_r <= slen_nxt;
        pval_r <= pval_nxt;
        disc_r <= disc_nxt;
      end
    end
  end

endmodule

[rtl/u8u16_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16_queue
// Short job queue between the decoder and the result sequencer.
// ----------------------------------------------------------------------------
module u8u16_queue import u8u16_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  job_t  push_job,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output job_t  head_job
);

  job_t                mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]     count_r, count_nxt;

  assign full       = (count_r == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

[rtl/u8u16_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16_back
// Walks each queued job one result per cycle into out_r unless stalled.
// ----------------------------------------------------------------------------
module u8u16_back import u8u16_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  head_valid,
  input  job_t  head_job,
  output logic  pop,
  output logic  out_valid,
  input  logic  out_ready,
  output out_t  out_data
);

  logic [1:0]  sel_r, sel_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_t        out_r;
  logic        load;
  logic        last;

  assign load      = head_valid && (!out_valid_r || out_ready);
  assign last      = (sel_r == head_job.num - 2'd1);
  assign pop       = load && last;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    sel_nxt       = sel_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      sel_nxt       = last ? 2'd0 : sel_r + 2'd1;
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r.result_kind <= head_job.slot[sel_r].result_kind;
      out_r.code_unit   <= head_job.slot[sel_r].code_unit;
      out_r.last_result <= last;
    end
  end

endmodule

[rtl/utf8_to_utf16_transcoder_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_core
// Strict UTF-8 decoder producing UTF-16 code units and text status.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_data): one byte per transfer, with a
// byte_present flag and an end_of_text flag closing the current text.
// Output channel (out_valid/out_ready/out_data): code units, then a done or
// error status per text; last_result marks the final result of a transfer.
// cfg_wr_en/cfg_wr_data set validate_only, which keeps only status results.
// A byte is decoded in the cycle it transfers and its results land in a
// four-entry job queue; the sequencer loads them from its head into out_data.
// Throughput is one byte per cycle while out_ready is high and each byte
// yields at most one result; extra results of a byte take the output register
// in turn; the queue absorbs the backlog until it fills and in_ready drops.
// Reset (rst_n low, synchronous) empties the queue and clears decoder state
// and validate_only. When out_ready is low the current result holds and
// bytes keep transferring until the queue is full.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder_core import u8u16_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  cfg_wr_en,
  input  logic  cfg_wr_data,
  input  logic  in_valid,
  output logic  in_ready,
  input  in_t   in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output out_t  out_data
);

  logic  accept;
  logic  push;
  logic  full;
  logic  pop;
  logic  head_valid;
  job_t  job;
  job_t  head_job;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  u8u16_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .in_data     (in_data),
    .push        (push),
    .job         (job)
  );

  u8u16_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (job),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  u8u16_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

[rtl/u8u16_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16_props
// Port-level checks of the transcoder's result channel.
// ----------------------------------------------------------------------------
module u8u16_props import u8u16_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  out_valid,
  input  logic  out_ready,
  input  out_t  out_data
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.result_kind == KIND_UNIT) ||
                  (out_data.result_kind == KIND_DONE) ||
                  (out_data.result_kind == KIND_ERROR))
    else $error("undefined result kind");

  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.result_kind != KIND_UNIT) |-> out_data.code_unit == 16'd0)
    else $error("status result carries a code unit");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.result_kind != KIND_UNIT) |-> out_data.last_result)
    else $error("status result not last");

endmodule

bind utf8_to_utf16_transcoder_core u8u16_props u_props (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

[tb/sv/u8u16_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16_checker
// Watches both channels and the mode register of the UTF-8 to UTF-16
// transcoder. It decodes every accepted byte with its own shadow decoder and
// queues the code units and status results due. Each result that leaves the
// block is compared field by field with the oldest one still due.
// ----------------------------------------------------------------------------
module u8u16_checker import u8u16_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_wr_en,
  input  logic cfg_wr_data,
  input  logic in_valid,
  input  logic in_ready,
  input  in_t  in_data,
  input  logic out_valid,
  input  logic out_ready,
  input  out_t out_data,
  output int   fail_count,
  output int   outstanding
);

  logic        text_only;
  logic [1:0]  need;
  logic [1:0]  seq_len;
  logic [20:0] acc;
  logic        dropping;
  out_t        burst[$];
  out_t        results_due[$];
  int          errors = 0;

  task automatic push_result(logic [1:0] kind, logic [15:0] unit);
    out_t r;
    r.result_kind = kind;
    r.code_unit   = unit;
    r.last_result = 1'b0;
    burst.insert(burst.size(), r);
  endtask

  task automatic flag_bad_text();
    push_result(KIND_ERROR, 16'h0000);
    dropping = 1'b1;
    need     = 2'd0;
    seq_len  = 2'd0;
    acc      = '0;
  endtask

  task automatic put_code_point(logic [20:0] cp);
    logic [20:0] adj;
    if (!text_only) begin
      if (cp <= 21'h00FFFF) begin
        push_result(KIND_UNIT, cp[15:0]);
      end else begin
        adj = cp - 21'h010000;
        push_result(KIND_UNIT, 16'hD800 | {6'b0, adj[19:10]});
        push_result(KIND_UNIT, 16'hDC00 | {6'b0, adj[9:0]});
      end
    end
  endtask

  task automatic decode_byte(logic [7:0] b);
    logic [20:0] floor_cp;
    logic [20:0] cp;
    if (!dropping) begin
      if (need == 2'd0) begin
        if (b[7] == 1'b0) begin
          put_code_point({13'b0, b});
        end else if (b[7:5] == 3'b110) begin
          need    = 2'd1;
          seq_len = 2'd1;
          acc     = {16'b0, b[4:0]};
        end else if (b[7:4] == 4'b1110) begin
          need    = 2'd2;
          seq_len = 2'd2;
          acc     = {17'b0, b[3:0]};
        end else if (b[7:3] == 5'b11110) begin
          need    = 2'd3;
          seq_len = 2'd3;
          acc     = {18'b0, b[2:0]};
        end else begin
          flag_bad_text();
        end
      end else if (b[7:6] != 2'b10) begin
        flag_bad_text();
      end else begin
        acc  = {acc[14:0], b[5:0]};
        need = need - 2'd1;
        if (need == 2'd0) begin
          case (seq_len)
            2'd1:    floor_cp = 21'h000080;
            2'd2:    floor_cp = 21'h000800;
            2'd3:    floor_cp = 21'h010000;
            default: floor_cp = 21'h000000;
          endcase
          if (acc < floor_cp || acc > 21'h10FFFF ||
              (acc >= 21'h00D800 && acc <= 21'h00DFFF)) begin
            flag_bad_text();
          end else begin
            cp      = acc;
            seq_len = 2'd0;
            acc     = '0;
            put_code_point(cp);
          end
        end
      end
    end
  endtask

  task automatic decode_item(in_t it);
    burst.delete();
    if (it.byte_present) begin
      decode_byte(it.data_byte);
    end
    if (it.end_of_text) begin
      if (!dropping) begin
        push_result((need != 2'd0) ? KIND_ERROR : KIND_DONE, 16'h0000);
      end
      need     = 2'd0;
      seq_len  = 2'd0;
      acc      = '0;
      dropping = 1'b0;
    end
    if (burst.size() > 0) begin
      burst[burst.size() - 1].last_result = 1'b1;
    end
    foreach (burst[i]) begin
      results_due.insert(results_due.size(), burst[i]);
    end
  endtask

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      text_only = 1'b0;
      need      = 2'd0;
      seq_len   = 2'd0;
      acc       = '0;
      dropping  = 1'b0;
      results_due.delete();
    end else begin
      if (cfg_wr_en) begin
        text_only = cfg_wr_data;
      end
      if (in_valid && in_ready) begin
        decode_item(in_data);
      end
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          if (errors < 10) begin
            $display("%0t unexpected result: kind %0d unit %h last %0b", $time,
                     out_data.result_kind, out_data.code_unit, out_data.last_result);
          end
          errors++;
        end else begin
          want = results_due.pop_front();
          if (out_data.result_kind !== want.result_kind ||
              out_data.code_unit !== want.code_unit ||
              out_data.last_result !== want.last_result) begin
            if (errors < 10) begin
              $display({"%0t result mismatch: expected kind %0d unit %h last %0b,",
                        " got kind %0d unit %h last %0b"},
                       $time, want.result_kind, want.code_unit, want.last_result,
                       out_data.result_kind, out_data.code_unit, out_data.last_result);
            end
            errors++;
          end
        end
      end
    end
    fail_count  <= errors;
    outstanding <= results_due.size();
  end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Regression for the UTF-8 to UTF-16 transcoder core. A short directed set
// covers the range limits and every kind of malformed text, then random
// texts, mostly well formed with some faults and noise, run in both modes
// under varying sender gaps, receiver stalls and one long receiver hold.
// ----------------------------------------------------------------------------
module tb_top;
  import u8u16_pkg::*;

  localparam int LONG_HOLD   = 300;
  localparam int DRAIN_TICKS = 8;

  typedef enum int {
    FAULT_NONE,
    FAULT_BAD_LEAD,
    FAULT_BAD_CONT,
    FAULT_OVERLONG,
    FAULT_SURROGATE,
    FAULT_TOO_LARGE,
    FAULT_CUT,
    FAULT_NOISE
  } fault_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic cfg_wr_data;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;
  int   fail_count;
  int   outstanding;

  int         tx_idle_pct  = 0;
  int         rx_stall_pct = 0;
  int         hold_token   = 0;
  int         items_sent   = 0;
  logic [7:0] text_bytes[$];

  utf8_to_utf16_transcoder_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  u8u16_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("utf8_to_utf16_transcoder_core regression: fail");
    $finish;
  end

  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  task automatic append_byte(logic [7:0] v);
    text_bytes.insert(text_bytes.size(), v);
  endtask

  function automatic logic [7:0] cont_byte();
    return {2'b10, 6'($urandom)};
  endfunction

  function automatic logic [20:0] random_code_point(int lo_class);
    logic [20:0] cp;
    case ($urandom_range(3, lo_class))
      0: cp = 21'($urandom_range(8'h7F));
      1: cp = 21'($urandom_range(12'h7FF, 8'h80));
      2: begin
        cp = 21'($urandom_range(16'hF7FF, 12'h800));
        if (cp >= 21'h00D800) begin
          cp += 21'h000800;
        end
      end
      default: cp = 21'($urandom_range(21'h10FFFF, 21'h010000));
    endcase
    return cp;
  endfunction

  task automatic add_code_point(logic [20:0] cp);
    if (cp < 21'h000080) begin
      append_byte(cp[7:0]);
    end else if (cp < 21'h000800) begin
      append_byte({3'b110, cp[10:6]});
      append_byte({2'b10, cp[5:0]});
    end else if (cp < 21'h010000) begin
      append_byte({4'b1110, cp[15:12]});
      append_byte({2'b10, cp[11:6]});
      append_byte({2'b10, cp[5:0]});
    end else begin
      append_byte({5'b11110, cp[20:18]});
      append_byte({2'b10, cp[17:12]});
      append_byte({2'b10, cp[11:6]});
      append_byte({2'b10, cp[5:0]});
    end
  endtask

  task automatic add_fault(fault_t fault);
    logic [7:0] lead;
    logic [7:0] bad;
    int         k;
    case (fault)
      FAULT_BAD_LEAD: begin
        append_byte($urandom_range(1) ? 8'($urandom_range(8'hBF, 8'h80))
                                      : 8'($urandom_range(8'hFF, 8'hF8)));
      end
      FAULT_BAD_CONT: begin
        k = $urandom_range(2);
        case (k)
          0:       append_byte(8'($urandom_range(8'hDF, 8'hC2)));
          1:       append_byte(8'($urandom_range(8'hEC, 8'hE1)));
          default: append_byte(8'($urandom_range(8'hF3, 8'hF1)));
        endcase
        repeat ($urandom_range(k)) append_byte(cont_byte());
        bad = 8'($urandom);
        if (bad[7:6] == 2'b10) begin
          bad[6] = 1'b1;
        end
        append_byte(bad);
      end
      FAULT_OVERLONG: begin
        case ($urandom_range(2))
          0: begin
            append_byte(8'($urandom_range(8'hC1, 8'hC0)));
            append_byte(cont_byte());
          end
          1: begin
            append_byte(8'hE0);
            append_byte(8'($urandom_range(8'h9F, 8'h80)));
            append_byte(cont_byte());
          end
          default: begin
            append_byte(8'hF0);
            append_byte(8'($urandom_range(8'h8F, 8'h80)));
            append_byte(cont_byte());
            append_byte(cont_byte());
          end
        endcase
      end
      FAULT_SURROGATE: begin
        append_byte(8'hED);
        append_byte(8'($urandom_range(8'hBF, 8'hA0)));
        append_byte(cont_byte());
      end
      FAULT_TOO_LARGE: begin
        lead = 8'($urandom_range(8'hF7, 8'hF4));
        append_byte(lead);
        append_byte((lead == 8'hF4) ? 8'($urandom_range(8'hBF, 8'h90)) : cont_byte());
        append_byte(cont_byte());
        append_byte(cont_byte());
      end
      FAULT_CUT: begin
        k = text_bytes.size();
        add_code_point(random_code_point(1));
        repeat ($urandom_range(text_bytes.size() - k - 1, 1)) void'(text_bytes.pop_back());
      end
      default: begin
        repeat ($urandom_range(4, 1)) append_byte(8'($urandom));
      end
    endcase
  endtask

  task automatic build_text();
    int     n_cp;
    int     at;
    fault_t fault;
    text_bytes.delete();
    n_cp  = $urandom_range(6);
    at    = $urandom_range(n_cp);
    fault = ($urandom_range(9) < 7) ? FAULT_NONE
                                    : fault_t'($urandom_range(FAULT_NOISE, FAULT_BAD_LEAD));
    for (int i = 0; i <= n_cp; i++) begin
      if (i == at && fault != FAULT_NONE) begin
        add_fault(fault);
        if (fault == FAULT_CUT) begin
          break;
        end
      end
      if (i < n_cp) begin
        add_code_point(random_code_point(0));
      end
    end
  endtask

  task automatic send_item(in_t beat);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
    if (beat.byte_present || beat.end_of_text) begin
      items_sent++;
    end
  endtask

  task automatic send_text(bit bare_end, int idle_pct);
    in_t beat;
    for (int i = 0; i < text_bytes.size(); i++) begin
      if ($urandom_range(99) < idle_pct) begin
        beat = '{data_byte: 8'($urandom), byte_present: 1'b0, end_of_text: 1'b0};
        send_item(beat);
      end
      beat = '{data_byte: text_bytes[i], byte_present: 1'b1,
               end_of_text: !bare_end && i == text_bytes.size() - 1};
      send_item(beat);
    end
    if (bare_end || text_bytes.size() == 0) begin
      beat = '{data_byte: 8'($urandom), byte_present: 1'b0, end_of_text: 1'b1};
      send_item(beat);
    end
  endtask

  task automatic set_validate_only(bit on);
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_TICKS) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= on;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic run_phase(bit on, int tx_pct, int rx_pct, bit hold, int n_items);
    int start;
    set_validate_only(on);
    tx_idle_pct   = tx_pct;
    rx_stall_pct <= rx_pct;
    if (hold) begin
      hold_token <= hold_token + 1;
    end
    start = items_sent;
    while (items_sent - start < n_items) begin
      build_text();
      send_text($urandom_range(4) == 0, 5);
    end
  endtask

  initial begin
    in_t beat;
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    set_validate_only(1'b0);
    text_bytes.delete();
    send_text(1'b1, 0);
    beat = '{data_byte: 8'hFF, byte_present: 1'b0, end_of_text: 1'b0};
    send_item(beat);
    text_bytes = '{8'h00, 8'h7F, 8'hDF, 8'hBF, 8'hEF, 8'hBF, 8'hBF,
                   8'hF4, 8'h8F, 8'hBF, 8'hBF};
    send_text(1'b0, 0);
    text_bytes = '{8'hFF, 8'h41};
    send_text(1'b0, 0);
    text_bytes = '{8'hC2, 8'h41};
    send_text(1'b0, 0);
    text_bytes = '{8'hC0, 8'h80};
    send_text(1'b0, 0);
    text_bytes = '{8'hED, 8'hA0, 8'h80};
    send_text(1'b0, 0);
    text_bytes = '{8'hF4, 8'h90, 8'h80, 8'h80};
    send_text(1'b0, 0);
    text_bytes = '{8'hE0, 8'hA0};
    send_text(1'b0, 0);

    run_phase(1'b1, 0, 0, 1'b0, 60);
    run_phase(1'b0, 57, 0, 1'b0, 60);
    run_phase(1'b1, 0, 57, 1'b0, 60);
    run_phase(1'b0, 14, 14, 1'b0, 60);
    run_phase(1'b0, 0, 0, 1'b1, 60);
    run_phase(1'b0, 0, 0, 1'b0, 60);

    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("utf8_to_utf16_transcoder_core regression: pass");
    end else begin
      $display("utf8_to_utf16_transcoder_core regression: fail");
    end
    $finish;
  end

endmodule
